@@ sv/sbs_pkg.sv @@
// ============================================================================
// Sorted table binary search: shared package
// Widths, operation codes, the queued command type and the sequencer states
// used by the front and back parts of the search core.
// ============================================================================
package sbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = IDX_W + 1;
    localparam int DATA_W      = 32;
    localparam int MATCH_W     = IDX_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // Operation codes carried in the func field.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // Index reported when the key is absent (-1).
    localparam logic signed [MATCH_W-1:0] NOT_FOUND = '1;

    // One classified operation waiting between the front and back parts.
    typedef struct packed {
        logic                      is_search;
        logic [IDX_W-1:0]          index;
        logic signed [DATA_W-1:0]  value;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_RESULT
    } back_state_t;

endpackage

@@ sv/sbs_channels.sv @@
// ============================================================================
// Sorted table binary search: channel interfaces
// Request channel (write or search operations) and response channel (search
// results), each with valid/ready flow control.
// ============================================================================
interface sbs_req_if;
    import sbs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] search_key;

    modport source (output valid, func, entry_index, entry_value, search_key,
                    input ready);
    modport sink   (input valid, func, entry_index, entry_value, search_key,
                    output ready);
endinterface

interface sbs_rsp_if;
    import sbs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      found;
    logic signed [MATCH_W-1:0] match_index;

    modport source (output valid, found, match_index, input ready);
    modport sink   (input valid, found, match_index, output ready);
endinterface

@@ sv/sbs_front.sv @@
// ============================================================================
// Sorted table binary search: front part
// Accepts request beats, classifies them into write or search commands and
// holds them in a small queue until the back part takes them.
// ============================================================================
module sbs_front (
    input  logic         clk,
    input  logic         rst_n,
    sbs_req_if.sink      req,
    output sbs_pkg::cmd_t q_cmd,
    output logic         q_valid,
    input  logic         q_pop
);
    import sbs_pkg::*;

    cmd_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_CW-1:0]  count_reg;
    logic [QUEUE_CW-1:0]  count_next;
    cmd_t                 cmd_in;
    logic                 push;
    logic                 pop;

    // A search carries its key in the value slot; a write carries its data.
    always_comb
    begin
        cmd_in.is_search = (req.func == FUNC_SEARCH);
        cmd_in.index     = req.entry_index;
        cmd_in.value     = (req.func == FUNC_SEARCH) ? req.search_key : req.entry_value;
    end

    assign req.ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_cmd     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ sv/sbs_back.sv @@
// ============================================================================
// Sorted table binary search: back part
// Owns the table memory and the length register. A write completes in the
// idle state as it is popped; a search runs as a sequence of read and compare
// steps and leaves its result in the response output register.
// ============================================================================
module sbs_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sbs_pkg::LEN_W-1:0]  cfg_wdata,
    input  sbs_pkg::cmd_t              q_cmd,
    input  logic                       q_valid,
    output logic                       q_pop,
    sbs_rsp_if.source                  rsp
);
    import sbs_pkg::*;

    logic signed [DATA_W-1:0]  mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0]  rd_data_reg;

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [LEN_W-1:0]          len_reg;
    logic [LEN_W-1:0]          len_next;
    logic [LEN_W-1:0]          lo_reg;
    logic [LEN_W-1:0]          lo_next;
    logic [LEN_W-1:0]          hi_ex_reg;
    logic [LEN_W-1:0]          hi_ex_next;
    logic [IDX_W-1:0]          mid_reg;
    logic [IDX_W-1:0]          mid_next;
    logic signed [DATA_W-1:0]  key_reg;
    logic signed [DATA_W-1:0]  key_next;
    logic                      hit_reg;
    logic                      hit_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_found_reg;
    logic                      out_found_next;
    logic signed [MATCH_W-1:0] out_index_reg;
    logic signed [MATCH_W-1:0] out_index_next;

    logic [LEN_W-1:0]          span_m1;
    logic [LEN_W-1:0]          mid_full;
    logic                      range_empty;
    logic                      slot_free;
    logic                      mem_we;

    // The search keeps an exclusive upper bound, so the empty range test is
    // a plain unsigned compare and the bounds never go negative.
    assign span_m1     = hi_ex_reg - lo_reg - LEN_W'(1);
    assign mid_full    = lo_reg + (span_m1 >> 1);
    assign range_empty = (lo_reg >= hi_ex_reg);
    assign slot_free   = !out_valid_reg || rsp.ready;

    always_comb
    begin
        len_next = len_reg;
        if (cfg_we)
        begin
            len_next = (cfg_wdata > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : cfg_wdata;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_cmd.is_search)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                state_next = range_empty ? ST_RESULT : ST_CMP;
            end
            ST_CMP:
            begin
                state_next = (rd_data_reg == key_reg) ? ST_RESULT : ST_PROBE;
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        lo_next        = lo_reg;
        hi_ex_next     = hi_ex_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_found_next = out_found_reg;
        out_index_next = out_index_reg;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop = 1'b1;
                if (q_valid)
                begin
                    if (q_cmd.is_search)
                    begin
                        lo_next    = '0;
                        hi_ex_next = len_reg;
                        key_next   = q_cmd.value;
                        hit_next   = 1'b0;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
            end
            ST_PROBE:
            begin
                mid_next = mid_full[IDX_W-1:0];
            end
            ST_CMP:
            begin
                if (rd_data_reg == key_reg)
                begin
                    hit_next = 1'b1;
                end
                else if (key_reg < rd_data_reg)
                begin
                    hi_ex_next = {1'b0, mid_reg};
                end
                else
                begin
                    lo_next = {1'b0, mid_reg} + LEN_W'(1);
                end
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = hit_reg;
                    out_index_next = hit_reg ? $signed({1'b0, mid_reg}) : NOT_FOUND;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_ex_reg     <= hi_ex_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        hit_reg       <= hit_next;
        out_found_reg <= out_found_next;
        out_index_reg <= out_index_next;
    end

    // Table memory: one write port, one registered read port at the probe.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_cmd.index] <= q_cmd.value;
        end
        rd_data_reg <= mem[mid_full[IDX_W-1:0]];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.match_index = out_index_reg;

endmodule

@@ sv/sorted_table_binary_search_core.sv @@
// ============================================================================
// Sorted table binary search core
// Holds a table of signed 32-bit entries in ascending order and answers
// binary search requests over the first table_length entries.
// ============================================================================
//
//   Channel | Direction | Handshake     | Beat contents
//   --------+-----------+---------------+-----------------------------------------
//   req     | in        | valid/ready   | func, entry_index, entry_value, search_key
//   rsp     | out       | valid/ready   | found, match_index
//   cfg     | in        | cfg_we strobe | cfg_wdata = table_length
//
// A write beat is done in the back part's idle state as it leaves the queue.
// A search runs a probe state (memory read) and a compare state (compare
// and bound update) for each probe, then a result state; the single memory
// read port sets the probe rate. Reset is asynchronous and active low; the
// table memory is not cleared and is valid only where written. A stalled
// rsp holds its beat while the two-deep queue keeps accepting req beats
// until it fills.
//
// The front part classifies each request beat into a command and queues it,
// so request flow control depends only on queue space. The back part pops
// one command at a time, runs writes and searches in order, and parks each
// result in an output register that the response side drains on its own.
// table_length is clamped to the table depth as it is written.
module sorted_table_binary_search_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [sbs_pkg::LEN_W-1:0] cfg_wdata,
    sbs_req_if.sink                   req,
    sbs_rsp_if.source                 rsp
);
    import sbs_pkg::*;

    cmd_t q_cmd;
    logic q_valid;
    logic q_pop;

    sbs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    sbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_cmd     (q_cmd),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .rsp       (rsp)
    );

endmodule

@@ sv/sbs_checker.sv @@
// ============================================================================
// Sorted table binary search: port checker
// Watches the response channel of the core and checks the result encoding
// and reset behavior.
// ============================================================================
module sbs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_found,
    input logic [sbs_pkg::MATCH_W-1:0] rsp_match_index
);
    import sbs_pkg::*;

    // No result beat is offered in the cycle after reset has been seen.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !rsp_valid)
        else $error("response valid during reset");

    // A stalled result beat keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found)
                                        && $stable(rsp_match_index)))
        else $error("stalled response beat changed");

    // A miss always reports an index of -1.
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_found) |-> (rsp_match_index == MATCH_W'(NOT_FOUND)))
        else $error("miss reported with an index other than -1");

    // A hit always reports a non-negative index.
    a_hit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_found) |-> !rsp_match_index[MATCH_W-1])
        else $error("hit reported with a negative index");

endmodule

bind sorted_table_binary_search_core sbs_checker u_sbs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_found       (rsp.found),
    .rsp_match_index (rsp.match_index)
);

@@ tb/sv/testbench.sv @@
// ============================================================================
// Sorted table binary search core: self-checking testbench
// Loads the table through write beats, sets table_length through the
// configuration port and checks every search result against a predictor
// that runs the same binary search over a shadow copy of the table.
// ============================================================================
module testbench;
    import sbs_pkg::*;

    localparam int  CLK_HALF       = 4;
    localparam int  RESET_CYCLES   = 8;
    localparam int  RANDOM_ITEMS   = 120;
    // The request queue holds two commands and a write is done as it leaves
    // the queue, so this idle stretch is enough for any write still in flight.
    localparam int  DRAIN_CYCLES   = 64;
    localparam int  LONG_HOLD      = 300;
    localparam int  CYCLE_LIMIT    = 1000000;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // One request beat waiting to be offered to the core.
    typedef struct {
        logic                     func;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] search_key;
    } req_beat_t;

    // What one search is expected to return.
    typedef struct packed {
        logic                      found;
        logic signed [MATCH_W-1:0] match_index;
    } search_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    sbs_req_if req_ch ();
    sbs_rsp_if rsp_ch ();

    sorted_table_binary_search_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Beats still to be offered, and search results still owed by the core.
    req_beat_t      pend_beats[$];
    search_result_t awaited_results[$];

    // Shadow of the core's table and clamped length, updated as beats are
    // accepted. The generator keeps its own view of the planned contents so
    // that it can pick keys that hit.
    logic signed [DATA_W-1:0] shadow_entries [TABLE_DEPTH];
    int                       shadow_len;
    logic signed [DATA_W-1:0] plan_vals [TABLE_DEPTH];

    int  mismatch_count;
    int  results_seen;
    int  cycle_count;
    bit  beat_taken;

    // Sender burst state and receiver stall state.
    int  burst_left;
    int  gap_left;
    int  stall_mode;
    int  pattern_left;
    int  hold_left;
    int  next_hold_at;

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: the classic binary search over the first shadow_len entries.
    // The search stops at the first probe that equals the key, so with
    // duplicate values the reported index is the one the probe order hits
    // first, not necessarily the lowest.
    // ------------------------------------------------------------------------
    function automatic search_result_t probe_table(input logic signed [DATA_W-1:0] key);
        search_result_t res;
        int lo;
        int hi;
        int mid;
        lo              = 0;
        hi              = shadow_len - 1;
        mid             = 0;
        res.found       = 1'b0;
        res.match_index = NOT_FOUND;
        while (hi >= lo)
        begin
            mid = lo + (hi - lo) / 2;
            if (shadow_entries[mid] == key)
            begin
                res.found       = 1'b1;
                res.match_index = MATCH_W'(mid);
                break;
            end
            else if (key < shadow_entries[mid])
            begin
                hi = mid - 1;
            end
            else
            begin
                lo = mid + 1;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Generator helpers. Unused fields of a beat carry random bits so that
    // the core is seen to ignore them.
    // ------------------------------------------------------------------------
    task automatic push_write(input int idx, input logic signed [DATA_W-1:0] value);
        req_beat_t b;
        b.func        = FUNC_WRITE;
        b.entry_index = IDX_W'(idx);
        b.entry_value = value;
        b.search_key  = $urandom;
        plan_vals[idx] = value;
        pend_beats.push_back(b);
    endtask

    task automatic push_search(input logic signed [DATA_W-1:0] key);
        req_beat_t b;
        b.func        = FUNC_SEARCH;
        b.entry_index = IDX_W'($urandom);
        b.entry_value = $urandom;
        b.search_key  = key;
        pend_beats.push_back(b);
    endtask

    // Fills entries 0..len-1 in ascending order. A small step gives runs of
    // equal values; values that would pass the top of the range saturate,
    // which also leaves duplicates of the largest value.
    task automatic load_sorted_entries(input int len, input longint step_max,
                                       input bit from_min);
        longint v;
        int i;
        if (from_min)
            v = VAL_MIN;
        else if ($urandom_range(0, 1) == 0)
            v = $signed($urandom);
        else
            v = -(longint'(len) * step_max) / 2;
        for (i = 0; i < len; i++)
        begin
            if (v > VAL_MAX)
                v = VAL_MAX;
            if (v < VAL_MIN)
                v = VAL_MIN;
            push_write(i, DATA_W'(v));
            v = v + $urandom_range(0, 32'(step_max));
        end
    endtask

    // Mostly keys that are in the table, then near misses, the range ends
    // and fully random keys.
    function automatic logic signed [DATA_W-1:0] pick_key(input int len);
        int r;
        logic signed [DATA_W-1:0] k;
        r = $urandom_range(0, 19);
        if (len == 0 || r >= 16)
            k = $urandom;
        else if (r < 10)
            k = plan_vals[$urandom_range(0, len - 1)];
        else if (r < 14)
            k = plan_vals[$urandom_range(0, len - 1)] + (r[0] ? 1 : -1);
        else
            k = r[0] ? VAL_MAX : VAL_MIN;
        return k;
    endfunction

    // Holds the sender back until every beat has gone in and every search
    // result has come out, then lets in-flight writes finish.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pend_beats.size() != 0 || awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // The core is idle whenever this is called, so the shadow length can
    // change at once. Lengths above the depth are clamped as in the core.
    task automatic set_table_length(input int len);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= LEN_W'(len);
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_len = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
    endtask

    // ------------------------------------------------------------------------
    // Request driver. A beat that has been offered stays on the bus until it
    // is taken. Between beats the sender runs bursts of random length with
    // random gaps, and about a quarter of the bursts have no gap at all.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (req_ch.valid && !beat_taken)
        begin
            // Still waiting for the core to take the current beat.
        end
        else
        begin
            beat_taken = 1'b0;
            if (gap_left != 0)
            begin
                req_ch.valid <= 1'b0;
                gap_left--;
            end
            else if (pend_beats.size() != 0)
            begin
                req_ch.valid       <= 1'b1;
                req_ch.func        <= pend_beats[0].func;
                req_ch.entry_index <= pend_beats[0].entry_index;
                req_ch.entry_value <= pend_beats[0].entry_value;
                req_ch.search_key  <= pend_beats[0].search_key;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response receiver. Ready follows a pattern that is redrawn after a random
    // run: always ready, coin flip, mostly stalled, or a fixed rhythm. At
    // least once in the run it holds off for a long stretch while the sender
    // keeps offering beats, so the request queue fills and the core stalls
    // its input.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (results_seen >= next_hold_at)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left     = LONG_HOLD - 1;
            next_hold_at  = (next_hold_at < 600) ? 600 : 32'h7fff_ffff;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                stall_mode   = $urandom_range(0, 3);
                pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            case (stall_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= (cycle_count % 3 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. On the request side each accepted beat updates the shadow
    // table or queues the expected result of its search; on the response side
    // each accepted beat is checked against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        search_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("sorted_table_binary_search_core test failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (req_ch.func == FUNC_WRITE)
                    shadow_entries[req_ch.entry_index] = req_ch.entry_value;
                else
                    awaited_results.push_back(probe_table(req_ch.search_key));
                pend_beats.delete(0);
                beat_taken = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat, expected none, got found=%0b index=%0d",
                             $time, rsp_ch.found, rsp_ch.match_index);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_ch.found !== want.found)
                    begin
                        mismatch_count++;
                        $display("%0t: found mismatch, expected %0b, got %0b",
                                 $time, want.found, rsp_ch.found);
                    end
                    if (rsp_ch.match_index !== want.match_index)
                    begin
                        mismatch_count++;
                        $display("%0t: match_index mismatch, expected %0d, got %0d",
                                 $time, want.match_index, rsp_ch.match_index);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. Every change of table_length happens with the core idle. Each
    // phase first writes all entries that its searches can probe, so an entry
    // that was never written is never read.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int random_items;
        int len;
        int n_search;
        int i;
        int r;
        longint step_max;

        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_WRITE;
        req_ch.entry_index = '0;
        req_ch.entry_value = '0;
        req_ch.search_key  = '0;
        rsp_ch.ready       = 1'b0;
        shadow_len         = 0;
        mismatch_count     = 0;
        results_seen       = 0;
        cycle_count        = 0;
        beat_taken         = 1'b0;
        burst_left         = 1;
        gap_left           = 0;
        stall_mode         = 0;
        pattern_left       = 0;
        hold_left          = 0;
        next_hold_at       = 40;
        random_items       = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Zero length straight out of reset: no probe, the key is never found.
        push_search(32'sd0);
        push_search(VAL_MIN);
        wait_for_drain();

        // A short table with both range ends, a pair of equal entries and gaps
        // between values, plus a write to the highest index.
        set_table_length(8);
        push_write(0, VAL_MIN);
        push_write(1, -32'sd1000);
        push_write(2, -32'sd1);
        push_write(3, 32'sd0);
        push_write(4, 32'sd0);
        push_write(5, 32'sd5);
        push_write(6, 32'sd1000);
        push_write(7, VAL_MAX);
        push_write(TABLE_DEPTH - 1, VAL_MAX);
        push_search(VAL_MIN);
        push_search(VAL_MAX);
        push_search(32'sd0);
        push_search(32'sd5);
        push_search(-32'sd2);
        push_search(32'sd1);
        push_search(VAL_MIN + 1);
        wait_for_drain();

        // A one-entry table: a single probe that either hits or ends the search.
        set_table_length(1);
        push_search(VAL_MIN);
        push_search(-32'sd1000);
        wait_for_drain();

        // Random phases, mostly short sorted tables with searches that hit,
        // now and then an unsorted table, an empty table or a stray write.
        while (random_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                len = 0;
            else if (r < 14)
                len = $urandom_range(1, 40);
            else if (r < 18)
                len = $urandom_range(41, 300);
            else
                len = $urandom_range(1, 4);

            wait_for_drain();
            set_table_length(len);

            if ($urandom_range(0, 6) == 0)
            begin
                for (i = 0; i < len; i++)
                    push_write(i, $urandom);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       step_max = 1;
                    1:       step_max = 8;
                    2:       step_max = 1000;
                    default: step_max = 1 << 20;
                endcase
                load_sorted_entries(len, step_max, 1'b0);
            end

            n_search = $urandom_range(8, 40);
            for (i = 0; i < n_search; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
                else
                    push_search(pick_key(len));
            end
            random_items += len + n_search;
        end

        // Full table from the lowest value up, saturating at the top, then
        // the largest writable length, which the core clamps to the depth, then the depth minus one.
        wait_for_drain();
        set_table_length(TABLE_DEPTH);
        load_sorted_entries(TABLE_DEPTH, 1 << 23, 1'b1);
        for (i = 0; i < 40; i++)
            push_search(pick_key(TABLE_DEPTH));
        wait_for_drain();
        set_table_length((1 << LEN_W) - 1);
        for (i = 0; i < 20; i++)
            push_search(pick_key(TABLE_DEPTH));
        wait_for_drain();
        set_table_length(TABLE_DEPTH - 1);
        for (i = 0; i < 20; i++)
            push_search(pick_key(TABLE_DEPTH - 1));
        wait_for_drain();

        if (mismatch_count == 0)
            $display("sorted_table_binary_search_core test passed");
        else
            $display("sorted_table_binary_search_core test failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/sbs_pkg.sv
sv/sbs_channels.sv
sv/sbs_front.sv
sv/sbs_back.sv
sv/sorted_table_binary_search_core.sv
sv/sbs_checker.sv
tb/sv/testbench.sv
